>>> design/sphs_pkg.sv
// Shared types, codes and sizes for the snap point hit search block.
package sphs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int NUM_CAT     = 7;
  localparam int DIST_W      = 10;
  localparam int ADDR_W      = 4;

  localparam logic [DIST_W-1:0] INIT_DIST = DIST_W'(1000);

  localparam logic [2:0] CAT_GRID   = 3'd6;
  localparam logic [2:0] SRC_ORIGIN = 3'd7;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_SNAPPED = 2'd2;
  localparam logic [1:0] ST_MISS    = 2'd3;

  localparam logic [1:0] REG_SCOPE    = 2'd0;
  localparam logic [1:0] REG_ENABLE   = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         category;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } sphs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         source;
    logic [7:0]         slot;
    logic signed [15:0] snap_x;
    logic signed [15:0] snap_y;
  } sphs_out_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } sphs_entry_t;

  localparam int ENTRY_W = $bits(sphs_entry_t);

endpackage

>>> design/sphs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/snap_point_hit_search_core.sv
// Snap point table with add, category clear and cursor hit search.
// Add: one slot tested per cycle, from slot 0 upward, for the lowest free one.
// Clear: one table read per cycle through the point RAM.
// Query: the origin is tested first; each enabled category is then a full
// RAM pass through the one shared hit/distance unit (grid only while no hit). One item at a time.
// Reset is asynchronous, active low: all slots invalid, registers to their defaults.
module snap_point_hit_search_core
  import sphs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sphs_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sphs_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ORIGIN,
    S_NEXTCAT,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e                   state_q, state_d;
  logic [7:0]               scope_q, scope_d;
  logic [NUM_CAT-1:0]       enable_q, enable_d;
  logic signed [15:0]       origin_x_q, origin_x_d;
  logic signed [15:0]       origin_y_q, origin_y_d;
  logic [TABLE_DEPTH-1:0]   valid_q, valid_d;
  logic [1:0]               op_q, op_d;
  logic [2:0]               cat_q, cat_d;
  logic signed [15:0]       cx_q, cx_d;
  logic signed [15:0]       cy_q, cy_d;
  logic [SLOT_W-1:0]        addr_q, addr_d;
  logic                     iss_vld_q, iss_vld_d;
  logic [SLOT_W-1:0]        iss_slot_q, iss_slot_d;
  logic                     found_q, found_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic [2:0]               win_src_q, win_src_d;
  logic [SLOT_W-1:0]        win_slot_q, win_slot_d;
  logic signed [15:0]       win_x_q, win_x_d;
  logic signed [15:0]       win_y_q, win_y_d;
  sphs_out_t                res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  sphs_out_t                out_data_q, out_data_d;

  logic                     cfg_write;
  logic                     in_xfer;
  logic                     at_last;
  logic [NUM_CAT:0]         en_ext;

  // RAM port
  logic                     ram_we;
  logic                     ram_re;
  sphs_entry_t              ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  sphs_entry_t              rd_entry;

  // Shared hit/distance unit
  logic signed [15:0]       px, py;
  logic signed [16:0]       ddx, ddy, s17;
  logic [15:0]              adx, ady;
  logic                     hit, take_x, take_y, cand;

  sphs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = sphs_entry_t'(ram_rdata);
  assign ram_wdata = '{kind: cat_q, y: cy_q, x: cx_q};
  assign ram_we    = (state_q == S_ADD) && !valid_q[addr_q];
  assign ram_re    = (state_q == S_SCAN);

  assign cfg_write = psel && penable && pwrite;
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign at_last   = (addr_q == SLOT_W'(TABLE_DEPTH - 1));
  assign en_ext    = {1'b0, enable_q};

  assign pready     = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    case (paddr[3:2])
      REG_SCOPE:    prdata = 32'(scope_q);
      REG_ENABLE:   prdata = 32'(enable_q);
      REG_ORIGIN_X: prdata = 32'(origin_x_q);
      REG_ORIGIN_Y: prdata = 32'(origin_y_q);
      default:      prdata = '0;
    endcase
  end

  // Hit test and axis distances for either the origin or the entry just read
  always_comb begin
    if (state_q == S_ORIGIN) begin
      px = origin_x_q;
      py = origin_y_q;
    end else begin
      px = rd_entry.x;
      py = rd_entry.y;
    end
    s17    = $signed({9'd0, scope_q});
    ddx    = $signed({cx_q[15], cx_q}) - $signed({px[15], px});
    ddy    = $signed({cy_q[15], cy_q}) - $signed({py[15], py});
    adx    = ddx[16] ? 16'(-ddx) : 16'(ddx);
    ady    = ddy[16] ? 16'(-ddy) : 16'(ddy);
    hit    = (ddx >= -s17) && (ddx < s17) && (ddy >= -s17) && (ddy < s17);
    take_x = adx < 16'(dist_q);
    take_y = ady < 16'(dist_q);
    cand   = (state_q == S_ORIGIN)
          || (iss_vld_q && (op_q == OP_QUERY) && valid_q[iss_slot_q]
              && (rd_entry.kind == cat_q));
  end

  always_comb begin
    state_d     = state_q;
    scope_d     = scope_q;
    enable_d    = enable_q;
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    valid_d     = valid_q;
    op_d        = op_q;
    cat_d       = cat_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    addr_d      = addr_q;
    iss_vld_d   = 1'b0;
    iss_slot_d  = addr_q;
    found_d     = found_q;
    dist_d      = dist_q;
    win_src_d   = win_src_q;
    win_slot_d  = win_slot_q;
    win_x_d     = win_x_q;
    win_y_d     = win_y_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_write) begin
      case (paddr[3:2])
        REG_SCOPE:    scope_d    = pwdata[7:0];
        REG_ENABLE:   enable_d   = pwdata[NUM_CAT-1:0];
        REG_ORIGIN_X: origin_x_d = $signed(pwdata[15:0]);
        REG_ORIGIN_Y: origin_y_d = $signed(pwdata[15:0]);
        default:      ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Running minimum: |dx| first, then |dy|
    if (cand && hit && (take_x || take_y)) begin
      found_d    = 1'b1;
      dist_d     = take_x ? adx[DIST_W-1:0] : ady[DIST_W-1:0];
      win_src_d  = (state_q == S_ORIGIN) ? SRC_ORIGIN : cat_q;
      win_slot_d = (state_q == S_ORIGIN) ? '0 : iss_slot_q;
      win_x_d    = px;
      win_y_d    = py;
    end

    // Drop every entry of the category being cleared
    if (iss_vld_q && (op_q == OP_CLEAR) && valid_q[iss_slot_q]
        && (rd_entry.kind == cat_q)) begin
      valid_d[iss_slot_q] = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d   = in_data_i.op;
          cat_d  = in_data_i.category;
          cx_d   = in_data_i.x;
          cy_d   = in_data_i.y;
          addr_d = '0;
          res_d  = '{status: ST_DONE, source: 3'd0, slot: 8'd0, snap_x: '0, snap_y: '0};
          case (in_data_i.op)
            OP_ADD: begin
              if (in_data_i.category == SRC_ORIGIN) begin
                res_d.status = ST_FULL;
                state_d      = S_EMIT;
              end else begin
                state_d = S_ADD;
              end
            end
            OP_CLEAR: state_d = S_SCAN;
            OP_QUERY: begin
              found_d    = 1'b0;
              dist_d     = INIT_DIST;
              win_src_d  = '0;
              win_slot_d = '0;
              win_x_d    = '0;
              win_y_d    = '0;
              state_d    = S_ORIGIN;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_ADD: begin
        if (!valid_q[addr_q]) begin
          valid_d[addr_q] = 1'b1;
          res_d   = '{status: ST_DONE, source: cat_q, slot: 8'(addr_q),
                      snap_x: cx_q, snap_y: cy_q};
          state_d = S_EMIT;
        end else if (at_last) begin
          res_d.status = ST_FULL;
          state_d      = S_EMIT;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_ORIGIN: begin
        cat_d   = '0;
        state_d = S_NEXTCAT;
      end
      S_NEXTCAT: begin
        addr_d = '0;
        if (cat_q < CAT_GRID) begin
          if (en_ext[cat_q]) begin
            state_d = S_SCAN;
          end else begin
            cat_d = cat_q + 1'b1;
          end
        end else if ((cat_q == CAT_GRID) && en_ext[cat_q] && !found_q) begin
          state_d = S_SCAN;
        end else begin
          if (found_q) begin
            res_d = '{status: ST_SNAPPED, source: win_src_q, slot: 8'(win_slot_q),
                      snap_x: win_x_q, snap_y: win_y_q};
          end else begin
            res_d.status = ST_MISS;
          end
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        iss_vld_d  = 1'b1;
        iss_slot_d = addr_q;
        if (at_last) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (op_q == OP_CLEAR) begin
          state_d = S_EMIT;
        end else begin
          cat_d   = cat_q + 1'b1;
          state_d = S_NEXTCAT;
        end
      end
      S_EMIT: begin
        // Hold the result until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scope_q     <= 8'd4;
      enable_q    <= '1;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      valid_q     <= '0;
      op_q        <= OP_ADD;
      cat_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      addr_q      <= '0;
      iss_vld_q   <= 1'b0;
      iss_slot_q  <= '0;
      found_q     <= 1'b0;
      dist_q      <= INIT_DIST;
      win_src_q   <= '0;
      win_slot_q  <= '0;
      win_x_q     <= '0;
      win_y_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      scope_q     <= scope_d;
      enable_q    <= enable_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      valid_q     <= valid_d;
      op_q        <= op_d;
      cat_q       <= cat_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      addr_q      <= addr_d;
      iss_vld_q   <= iss_vld_d;
      iss_slot_q  <= iss_slot_d;
      found_q     <= found_d;
      dist_q      <= dist_d;
      win_src_q   <= win_src_d;
      win_slot_q  <= win_slot_d;
      win_x_q     <= win_x_d;
      win_y_q     <= win_y_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (dist_q < INIT_DIST))
    else $error("winner distance not below the initial distance");

  a_add_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |=> ($countones(valid_q) <= $past($countones(valid_q)) + 1))
    else $error("add filled more than one slot");

  a_query_keeps_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && (op_q == OP_QUERY)) |=> $stable(valid_q))
    else $error("slot valid bits changed during a query");

endmodule
